[rtl/mrf_pkg.sv]
package mrf_pkg;

   // command codes on the request channel
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RX_BYTE = 1'b1;

   // result kinds
   localparam logic KIND_TX_BYTE = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;
   localparam logic [1:0] STATUS_BAD_ID  = 2'd3;

   // request frame contents
   localparam logic [7:0] FUNC_READ    = 8'h03;
   localparam logic [7:0] QTY_HI       = 8'h00;
   localparam logic [7:0] QTY_LO       = 8'h01;
   localparam logic [7:0] NO_SLAVE     = 8'h00;

   // request byte positions
   localparam logic [2:0] TX_SLAVE    = 3'd0;
   localparam logic [2:0] TX_FUNC     = 3'd1;
   localparam logic [2:0] TX_ADDR_HI  = 3'd2;
   localparam logic [2:0] TX_ADDR_LO  = 3'd3;
   localparam logic [2:0] TX_QTY_HI   = 3'd4;
   localparam logic [2:0] TX_QTY_LO   = 3'd5;
   localparam logic [2:0] TX_CRC_LO   = 3'd6;
   localparam logic [2:0] TX_CRC_HI   = 3'd7;

   // response frame byte positions and length
   localparam logic [3:0] RX_SLAVE    = 4'd0;
   localparam logic [3:0] RX_VAL_HI   = 4'd3;
   localparam logic [3:0] RX_VAL_LO   = 4'd4;
   localparam logic [3:0] RX_CRC_LO   = 4'd5;
   localparam logic [3:0] RX_CRC_HI   = 4'd6;
   localparam logic [3:0] FRAME_LEN   = 4'd7;
   localparam logic [3:0] COUNT_MAX   = 4'd8;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  unit_id;
      logic [15:0] reg_addr;
      logic [7:0]  rx_byte;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [15:0] value;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] value;
   } verdict_type;

   // one byte of CRC-16 (reflected, poly 0xA001)
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/modbus_rtu_read_frame_engine_core.sv]
// Modbus RTU read-holding-register engine (function 3, one register).
// Request channel (req_*): each beat is either a start command carrying a
// slave id and register address, or one received response byte, the last
// byte of a frame flagged by frame_end.
// Result channel (rsp_*): a start command yields eight transmit bytes
// (slave, 0x03, address, 0x0001, CRC low, CRC high), last set on the eighth;
// a slave id of zero yields a single bad-id verdict instead. A response byte
// with frame_end yields one verdict (ok / crc error / ignored) with the value.
// A verdict is offered in the cycle after its beat is accepted; the first
// transmit byte of a burst goes through the burst state and the result
// register. Response bytes go at one per cycle while req_ready is high. A
// burst holds req_ready low while its bytes go out, since the transmit CRC is
// built a byte a cycle as they are taken; the next beat waits for its end.
// The result register decouples the two sides: a new beat is taken in the
// same cycle the held result is taken. If the receiver stalls, the result
// holds and req_ready drops until it drains.
// Reset (synchronous) empties the output, stops any burst, clears the stored
// slave id and restarts frame reception with the CRC at 0xFFFF.
module modbus_rtu_read_frame_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrf_pkg::rsp_type rsp_data
);
   import mrf_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        acc;
   logic        is_req;
   logic        bad_req;
   logic        start;
   logic        byte_en;
   logic        verdict_fire;
   logic        tx_active;
   logic        tx_advance;
   rsp_type     tx_beat;
   verdict_type verdict;
   rsp_type     verdict_beat;
   rsp_type     bad_beat;

   // output slot is free when empty or being emptied this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !tx_active && out_free;
   assign acc       = req_valid && req_ready;

   assign is_req       = acc && (req_data.cmd == CMD_REQUEST);
   assign bad_req      = is_req && (req_data.unit_id == NO_SLAVE);
   assign start        = is_req && (req_data.unit_id != NO_SLAVE);
   assign byte_en      = acc && (req_data.cmd == CMD_RX_BYTE);
   assign verdict_fire = byte_en && req_data.frame_end;
   assign tx_advance   = tx_active && out_free;

   mrf_tx u_tx (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .sid     (req_data.unit_id),
      .addr    (req_data.reg_addr),
      .advance (tx_advance),
      .active  (tx_active),
      .beat    (tx_beat)
   );

   mrf_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .sid_load  (start),
      .sid       (req_data.unit_id),
      .byte_en   (byte_en),
      .rx_byte   (req_data.rx_byte),
      .frame_end (req_data.frame_end),
      .verdict   (verdict)
   );

   always_comb begin
      verdict_beat.kind    = KIND_VERDICT;
      verdict_beat.tx_byte = '0;
      verdict_beat.last    = 1'b1;
      verdict_beat.status  = verdict.status;
      verdict_beat.value   = verdict.value;

      bad_beat.kind    = KIND_VERDICT;
      bad_beat.tx_byte = '0;
      bad_beat.last    = 1'b1;
      bad_beat.status  = STATUS_BAD_ID;
      bad_beat.value   = '0;
   end

   // burst beats and verdicts never compete: req_ready is low during a burst
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (tx_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tx_beat;
      end else if (bad_req) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bad_beat;
      end else if (verdict_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = verdict_beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/mrf_rx.sv]
module mrf_rx (
   input  logic                clock,
   input  logic                reset,
   input  logic                sid_load,
   input  logic [7:0]          sid,
   input  logic                byte_en,
   input  logic [7:0]          rx_byte,
   input  logic                frame_end,
   output mrf_pkg::verdict_type verdict
);
   import mrf_pkg::*;

   logic [7:0]  expected_ff, expected_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] crc_rcv_ff, crc_rcv_in;

   logic        adv;
   logic [3:0]  count_upd;
   logic [15:0] crc_upd;

   assign adv = byte_en && (count_ff < COUNT_MAX);

   // state after storing this byte, before any restart
   always_comb begin
      count_upd  = adv ? count_ff + 4'd1 : count_ff;
      crc_upd    = (adv && count_ff < RX_CRC_LO) ? crc_byte(crc_ff, rx_byte) : crc_ff;
      first_in   = (adv && count_ff == RX_SLAVE) ? rx_byte : first_ff;
      value_in   = value_ff;
      crc_rcv_in = crc_rcv_ff;
      if (adv && count_ff == RX_VAL_HI) value_in[15:8]   = rx_byte;
      if (adv && count_ff == RX_VAL_LO) value_in[7:0]    = rx_byte;
      if (adv && count_ff == RX_CRC_LO) crc_rcv_in[7:0]  = rx_byte;
      if (adv && count_ff == RX_CRC_HI) crc_rcv_in[15:8] = rx_byte;
   end

   always_comb begin
      expected_in = sid_load ? sid : expected_ff;
      if (sid_load || (byte_en && frame_end)) begin
         count_in = '0;
         crc_in   = CRC_INIT;
      end else begin
         count_in = count_upd;
         crc_in   = crc_upd;
      end
   end

   always_comb begin
      verdict.value = '0;
      if (count_upd == FRAME_LEN && first_in == expected_ff) begin
         if (crc_upd == crc_rcv_in) begin
            verdict.status = STATUS_OK;
            verdict.value  = value_in;
         end else begin
            verdict.status = STATUS_CRC_ERR;
         end
      end else begin
         verdict.status = STATUS_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         count_ff    <= '0;
         crc_ff      <= CRC_INIT;
         first_ff    <= '0;
         value_ff    <= '0;
         crc_rcv_ff  <= '0;
      end else begin
         expected_ff <= expected_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         first_ff    <= first_in;
         value_ff    <= value_in;
         crc_rcv_ff  <= crc_rcv_in;
      end
   end

endmodule

[rtl/mrf_tx.sv]
module mrf_tx (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [7:0]       sid,
   input  logic [15:0]      addr,
   input  logic             advance,
   output logic             active,
   output mrf_pkg::rsp_type beat
);
   import mrf_pkg::*;

   logic        active_ff, active_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  sid_ff, sid_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cur_byte;

   always_comb begin
      case (idx_ff)
         TX_SLAVE:   cur_byte = sid_ff;
         TX_FUNC:    cur_byte = FUNC_READ;
         TX_ADDR_HI: cur_byte = addr_ff[15:8];
         TX_ADDR_LO: cur_byte = addr_ff[7:0];
         TX_QTY_HI:  cur_byte = QTY_HI;
         TX_QTY_LO:  cur_byte = QTY_LO;
         TX_CRC_LO:  cur_byte = crc_ff[7:0];
         TX_CRC_HI:  cur_byte = crc_ff[15:8];
         default:    cur_byte = '0;
      endcase
   end

   always_comb begin
      beat.kind    = KIND_TX_BYTE;
      beat.tx_byte = cur_byte;
      beat.last    = (idx_ff == TX_CRC_HI);
      beat.status  = STATUS_OK;
      beat.value   = '0;
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      sid_in    = sid_ff;
      addr_in   = addr_ff;
      crc_in    = crc_ff;
      if (start) begin
         active_in = 1'b1;
         idx_in    = TX_SLAVE;
         sid_in    = sid;
         addr_in   = addr;
         crc_in    = CRC_INIT;
      end else if (active_ff && advance) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff < TX_CRC_LO) crc_in = crc_byte(crc_ff, cur_byte);
         if (idx_ff == TX_CRC_HI) active_in = 1'b0;
      end
   end

   assign active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      sid_ff  <= sid_in;
      addr_ff <= addr_in;
      crc_ff  <= crc_in;
   end

endmodule

[verif/tb_top.sv]
// Checks the Modbus RTU read engine beat by beat against a behavioural model
// kept in this bench.
//
// The stimulus starts with a short table of hand-picked beats. These are:
// a frame before any request, a bad slave id, a good reply, a reply with a
// bad CRC, and a frame cut short by a fresh request. Random traffic follows.
// Most of it is well-formed request/reply exchanges, the rest are wrong
// address, wrong length, corrupted and stray bytes.
// Both sides idle at random, in phases. A final phase holds the receiver off
// for a long stretch so that the engine backs up and drops req_ready.
module tb_top;
   import mrf_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int PRINT_CAP    = 50;

   // how a table row's rx_byte is rewritten from the model's running CRC
   typedef enum logic [1:0] {
      PATCH_NONE,
      PATCH_CRC_LO,
      PATCH_CRC_HI,
      PATCH_CRC_BAD
   } crc_patch_type;

   typedef struct {
      req_type       item;
      crc_patch_type patch;
      bit            typed;   // want holds a hand-written result
      rsp_type       want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   modbus_rtu_read_frame_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // model state: mirrors the engine's frame reception
   logic [7:0]  mdl_slave;
   logic [3:0]  mdl_count;
   logic [15:0] mdl_crc;
   logic [7:0]  mdl_first;
   logic [15:0] mdl_value;
   logic [15:0] mdl_crc_rx;

   rsp_type      pending_rsp[$];   // result beats still owed by the engine
   stim_row_type stim_rows[$];

   int req_idle_pct;
   int rsp_stall_pct;
   bit hold_off_req;

   int beats_sent;
   int cmd_beats;
   int beats_checked;
   int mismatches;
   int cycle_count;
   int verdict_count[4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-16/MODBUS, one byte, bit-serial: feedback is taken from the data
   // bit and the register lsb together rather than pre-xoring the byte
   function automatic logic [15:0] crc16_modbus(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = {1'b0, acc[15:1]};
         if (fb) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   function automatic rsp_type verdict(input logic [1:0] st, input logic [15:0] val);
      rsp_type r;
      r.kind    = KIND_VERDICT;
      r.tx_byte = 8'h00;
      r.last    = 1'b1;
      r.status  = st;
      r.value   = val;
      return r;
   endfunction

   // unused fields are filled at random so that every input bit toggles
   function automatic req_type rx_beat(input logic [7:0] data, input logic fend);
      req_type b;
      b.cmd       = CMD_RX_BYTE;
      b.unit_id   = 8'($urandom_range(255));
      b.reg_addr  = 16'($urandom_range(65535));
      b.rx_byte   = data;
      b.frame_end = fend;
      return b;
   endfunction

   function automatic req_type req_beat(input logic [7:0] sid, input logic [15:0] addr);
      req_type b;
      b.cmd       = CMD_REQUEST;
      b.unit_id   = sid;
      b.reg_addr  = addr;
      b.rx_byte   = 8'($urandom_range(255));
      b.frame_end = 1'($urandom_range(1));
      return b;
   endfunction

   // Works out the result beats one accepted input beat causes and queues them.
   task automatic predict_rsp_beats(input req_type b);
      logic [7:0]  frame [8];
      logic [15:0] crc;
      rsp_type     r;
      if (b.cmd == CMD_REQUEST) begin
         if (b.unit_id == NO_SLAVE) begin
            // rejected outright, state untouched
            pending_rsp.push_back(verdict(STATUS_BAD_ID, 16'h0000));
         end else begin
            frame[TX_SLAVE]   = b.unit_id;
            frame[TX_FUNC]    = FUNC_READ;
            frame[TX_ADDR_HI] = b.reg_addr[15:8];
            frame[TX_ADDR_LO] = b.reg_addr[7:0];
            frame[TX_QTY_HI]  = QTY_HI;
            frame[TX_QTY_LO]  = QTY_LO;
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = crc16_modbus(crc, frame[i]);
            frame[TX_CRC_LO] = crc[7:0];
            frame[TX_CRC_HI] = crc[15:8];
            // a new request also throws away any half-received reply
            mdl_slave = b.unit_id;
            mdl_count = 4'd0;
            mdl_crc   = CRC_INIT;
            for (int i = 0; i < 8; i++) begin
               r.kind    = KIND_TX_BYTE;
               r.tx_byte = frame[i];
               r.last    = (i == 7);
               r.status  = STATUS_OK;
               r.value   = 16'h0000;
               pending_rsp.push_back(r);
            end
         end
      end else begin
         // bytes past the eighth are dropped, the count sticks at eight
         if (mdl_count < COUNT_MAX) begin
            if (mdl_count == RX_SLAVE) mdl_first = b.rx_byte;
            if (mdl_count < RX_CRC_LO) mdl_crc = crc16_modbus(mdl_crc, b.rx_byte);
            if (mdl_count == RX_VAL_HI) mdl_value[15:8] = b.rx_byte;
            if (mdl_count == RX_VAL_LO) mdl_value[7:0] = b.rx_byte;
            if (mdl_count == RX_CRC_LO) mdl_crc_rx[7:0] = b.rx_byte;
            if (mdl_count == RX_CRC_HI) mdl_crc_rx[15:8] = b.rx_byte;
            mdl_count = mdl_count + 4'd1;
         end
         if (b.frame_end) begin
            if (mdl_count == FRAME_LEN && mdl_first == mdl_slave) begin
               if (mdl_crc == mdl_crc_rx)
                  pending_rsp.push_back(verdict(STATUS_OK, mdl_value));
               else
                  pending_rsp.push_back(verdict(STATUS_CRC_ERR, 16'h0000));
            end else begin
               pending_rsp.push_back(verdict(STATUS_IGNORED, 16'h0000));
            end
            mdl_count = 4'd0;
            mdl_crc   = CRC_INIT;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatches < PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic add_row(input req_type item, input crc_patch_type patch,
                          input bit typed, input rsp_type want);
      stim_rows.push_back('{item, patch, typed, want});
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next call can carry straight on.
   task automatic send_beat(input req_type b);
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_rsp_beats(b);
      beats_sent++;
      if (b.cmd == CMD_REQUEST) cmd_beats++;
      @(negedge clock);
   endtask

   // Random exchanges: mostly requests and well-formed replies to the current
   // slave, with wrong-address, wrong-length, corrupted and stray beats mixed in.
   task automatic run_random_traffic(input int n_beats);
      int          stop_at;
      int          pick;
      int          len;
      int          flip;
      logic [7:0]  bytes [12];
      logic [15:0] crc;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            send_beat(req_beat(($urandom_range(19) == 0) ? NO_SLAVE
                                                          : 8'($urandom_range(1, 255)),
                               16'($urandom_range(65535))));
         end else if (pick < 94) begin
            len      = FRAME_LEN;
            bytes[0] = mdl_slave;
            bytes[1] = FUNC_READ;
            bytes[2] = 8'h02;
            bytes[3] = 8'($urandom_range(255));
            bytes[4] = 8'($urandom_range(255));
            crc = CRC_INIT;
            for (int i = 0; i < 5; i++) crc = crc16_modbus(crc, bytes[i]);
            bytes[5] = crc[7:0];
            bytes[6] = crc[15:8];
            for (int i = 7; i < 12; i++) bytes[i] = 8'($urandom_range(255));
            if (pick >= 84) begin
               // short or long frame, never exactly seven
               len = $urandom_range(1, 10);
               if (len >= FRAME_LEN) len++;
            end else if (pick >= 74) begin
               bytes[0] = mdl_slave ^ 8'($urandom_range(1, 255));
            end else if ($urandom_range(6) == 0) begin
               flip = $urandom_range(6);
               bytes[flip] = bytes[flip] ^ 8'(1 << $urandom_range(7));
            end
            for (int i = 0; i < len; i++) send_beat(rx_beat(bytes[i], i == len - 1));
         end else begin
            send_beat(rx_beat(8'($urandom_range(255)), 1'($urandom_range(1))));
         end
      end
   endtask

   // Receiver: random stalls, or a long hold-off counted here once asked for.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_left    = LONG_HOLD;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Result checker: every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (rsp_data.kind === KIND_VERDICT) verdict_count[rsp_data.status]++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("result beat with nothing owed, value", rsp_data.value, 16'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.kind !== want.kind)
               report_mismatch("kind", 16'(rsp_data.kind), 16'(want.kind));
            if (rsp_data.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 16'(rsp_data.tx_byte), 16'(want.tx_byte));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 16'(rsp_data.last), 16'(want.last));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 16'(rsp_data.status), 16'(want.status));
            if (rsp_data.value !== want.value)
               report_mismatch("value", rsp_data.value, want.value);
         end
      end
   end

   // Watchdog: ends a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result beats still owed",
                  cycle_count, pending_rsp.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      req_type      b;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_off_req  = 1'b0;
      beats_sent    = 0;
      cmd_beats     = 0;
      beats_checked = 0;
      mismatches    = 0;
      cycle_count   = 0;
      foreach (verdict_count[s]) verdict_count[s] = 0;
      mdl_slave  = NO_SLAVE;
      mdl_count  = 4'd0;
      mdl_crc    = CRC_INIT;
      mdl_first  = 8'h00;
      mdl_value  = 16'h0000;
      mdl_crc_rx = 16'h0000;

      // hand-picked opening beats
      // before any request the stored slave is zero; a one-byte frame is ignored
      add_row(rx_beat(8'h00, 1'b1), PATCH_NONE, 1'b1, verdict(STATUS_IGNORED, 16'h0));
      // slave zero: single bad-id verdict
      add_row(req_beat(NO_SLAVE, 16'h1234), PATCH_NONE, 1'b1, verdict(STATUS_BAD_ID, 16'h0));
      add_row(req_beat(8'h01, 16'h0000), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      // good reply, value all ones
      add_row(rx_beat(8'h01, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(FUNC_READ, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h02, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'hFF, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'hFF, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b0), PATCH_CRC_LO, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b1), PATCH_CRC_HI, 1'b0, verdict(STATUS_OK, 16'h0));
      // top slave id and address
      add_row(req_beat(8'hFF, 16'hFFFF), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      // reply with value zero and a CRC low byte that cannot match
      add_row(rx_beat(8'hFF, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(FUNC_READ, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h02, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b0), PATCH_CRC_BAD, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(8'h00, 1'b1), PATCH_CRC_HI, 1'b0, verdict(STATUS_OK, 16'h0));
      // half a reply, then a fresh request restarts reception
      add_row(rx_beat(8'h80, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(rx_beat(FUNC_READ, 1'b0), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      add_row(req_beat(8'h80, 16'h00FF), PATCH_NONE, 1'b0, verdict(STATUS_OK, 16'h0));
      // so a lone matching byte is a one-byte frame: ignored
      add_row(rx_beat(8'h80, 1'b1), PATCH_NONE, 1'b1, verdict(STATUS_IGNORED, 16'h0));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[k]) begin
         row = stim_rows[k];
         b   = row.item;
         case (row.patch)
            PATCH_CRC_LO:  b.rx_byte = mdl_crc[7:0];
            PATCH_CRC_HI:  b.rx_byte = mdl_crc[15:8];
            PATCH_CRC_BAD: b.rx_byte = ~mdl_crc[7:0];
            default: ;
         endcase
         send_beat(b);
         // the beat's result cannot leave before the next rising edge, so
         // the hand-written value can still stand in for the model's
         if (row.typed) pending_rsp[$] = row.want;
      end

      // random phases: no idling, sender idle, receiver stalling, both
      req_idle_pct = 0;  rsp_stall_pct = 0;  run_random_traffic(95);
      req_idle_pct = 60; rsp_stall_pct = 0;  run_random_traffic(95);
      req_idle_pct = 0;  rsp_stall_pct = 60; run_random_traffic(95);
      req_idle_pct = 22; rsp_stall_pct = 22; run_random_traffic(95);

      // back-pressure: receiver holds off while the sender keeps offering
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_off_req  = 1'b1;
      run_random_traffic(30);
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d input beats (%0d start commands), %0d result beats checked",
               beats_sent, cmd_beats, beats_checked);
      $display("verdicts ok/crc/ignored/bad-id: %0d/%0d/%0d/%0d, %0d mismatches",
               verdict_count[STATUS_OK], verdict_count[STATUS_CRC_ERR],
               verdict_count[STATUS_IGNORED], verdict_count[STATUS_BAD_ID], mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/mrf_pkg.sv
rtl/mrf_rx.sv
rtl/mrf_tx.sv
rtl/modbus_rtu_read_frame_engine_core.sv
verif/tb_top.sv
